[sv/aru_pkg.sv]
package aru_pkg;

	localparam int SAMPLE_W  = 32;
	localparam int WINDOW_MAX = 64;
	localparam int IDX_W     = $clog2(WINDOW_MAX);
	localparam int AGE_W     = 7;
	localparam int PCT_W     = 15;
	localparam int NUM_W     = PCT_W + IDX_W;
	localparam int DIV_STEPS = PCT_W;
	localparam int CNT_W     = $clog2(DIV_STEPS + 1);

	localparam logic [IDX_W-1:0] WINDOW_N_RESET = IDX_W'(20);
	localparam logic [PCT_W-1:0] Q8_FULL_SCALE  = PCT_W'(25600);
	localparam logic [AGE_W-1:0] AGE_LIMIT      = {AGE_W{1'b1}};

	// offset-binary key so that unsigned compares order signed samples
	typedef logic [SAMPLE_W-1:0] sample_t;

	localparam sample_t SIGN_BIT = {1'b1, {(SAMPLE_W-1){1'b0}}};

	// search token that walks from the oldest window cell toward the newest
	typedef struct packed {
		logic             v;
		sample_t          best;
		logic [IDX_W-1:0] gap;
	} tok_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN_START,
		ST_SCAN,
		ST_MUL,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

[sv/aru_cell.sv]
module aru_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            shift_en,
	input  aru_pkg::sample_t sample_in,
	output aru_pkg::sample_t sample_out,
	input  logic            start,
	input  aru_pkg::tok_t   tok_in,
	output aru_pkg::tok_t   tok_out
);
	import aru_pkg::*;

	sample_t          smp_q;
	logic             tok_v_q;
	sample_t          tok_best_q;
	logic [IDX_W-1:0] tok_gap_q;
	tok_t             tok_d;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			smp_q <= sample_in;
		end
	end

	// newer sample wins on ties, so the compare is >= as the token moves newer
	always_comb begin
		tok_d = tok_in;
		if (start) begin
			tok_d.v    = 1'b1;
			tok_d.best = smp_q;
			tok_d.gap  = '0;
		end else if (tok_in.v) begin
			if (smp_q >= tok_in.best) begin
				tok_d.best = smp_q;
				tok_d.gap  = '0;
			end else begin
				tok_d.gap = tok_in.gap + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_v_q <= 1'b0;
		end else begin
			tok_v_q <= tok_d.v;
		end
	end

	always_ff @(posedge clk) begin
		tok_best_q <= tok_d.best;
		tok_gap_q  <= tok_d.gap;
	end

	assign sample_out = smp_q;
	assign tok_out    = {tok_v_q, tok_best_q, tok_gap_q};

endmodule

[sv/aru_div.sv]
module aru_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [aru_pkg::NUM_W-1:0]   num,
	input  logic [aru_pkg::IDX_W-1:0]   den,
	output logic                        done,
	output logic [aru_pkg::PCT_W-1:0]   quot
);
	import aru_pkg::*;

	logic [IDX_W-1:0] rem_q;
	logic [PCT_W-1:0] low_q;
	logic [PCT_W-1:0] quot_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [IDX_W:0]   trial;
	logic [IDX_W:0]   diff;
	logic             ge;

	// remainder stays below den, so one extra bit covers the trial value
	assign trial = {rem_q, low_q[PCT_W-1]};
	assign ge    = trial >= {1'b0, den};
	assign diff  = trial - {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// quotient fits PCT_W bits, so the top bits are already below den
			rem_q  <= num[NUM_W-1:PCT_W];
			low_q  <= num[PCT_W-1:0];
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[IDX_W-1:0] : trial[IDX_W-1:0];
			low_q  <= {low_q[PCT_W-2:0], 1'b0};
			quot_q <= {quot_q[PCT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

[sv/aroon_up_rolling_max_age_top.sv]
// Aroon-up over a rolling window of n+1 samples (n from window_n, 0 read as 1),
// one result per accepted sample: floor(25600*(n-age)/n), percent in Q8, where
// age is the distance back to the newest maximum. The first n samples after
// reset or a window_n write only warm up and come out with result_valid low
// and a value of 0; a write to window_n restarts warm-up. Samples sit in a row
// of 64 cells that shift on every accepted sample. An item is processed one
// at a time: a warm-up item skips the divider, a normal item waits on the
// 15-step serial divider, and when the maximum has aged out of the window
// a search token first walks down n cells before the division starts.
// The finished result sits in an output register, so a new sample is taken
// while the previous result is still stalled. No clearing pass is needed
// after reset.
module aroon_up_rolling_max_age_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [aru_pkg::IDX_W-1:0]          window_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [aru_pkg::SAMPLE_W-1:0] sample,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               result_valid,
	output logic [aru_pkg::PCT_W-1:0]          aroon_percent_q8
);
	import aru_pkg::*;

	state_t state_q;
	state_t state_d;

	logic [IDX_W-1:0] window_q;
	logic [IDX_W-1:0] wcnt_q;
	logic [AGE_W-1:0] age_q;
	sample_t          cur_q;
	logic             res_valid_q;
	logic [PCT_W-1:0] res_pct_q;
	logic             ov_q;
	logic             orv_q;
	logic [PCT_W-1:0] opct_q;

	logic [IDX_W-1:0] n_eff;
	sample_t          key;
	logic             accept;
	logic             warm;
	logic             rescan;
	logic             out_free;
	logic             scan_start;
	logic             div_start;
	logic             out_load;
	logic             div_done;
	logic [PCT_W-1:0] div_quot;
	logic [IDX_W-1:0] age_clip;
	logic [NUM_W-1:0] num;
	logic [AGE_W-1:0] age_inc;

	sample_t cell_smp [WINDOW_MAX];
	tok_t    cell_tok [WINDOW_MAX];

	assign n_eff    = (window_q == '0) ? IDX_W'(1) : window_q;
	assign key      = sample_t'(sample) ^ SIGN_BIT;
	assign accept   = in_valid && !in_stall;
	assign warm     = wcnt_q < n_eff;
	assign rescan   = age_q > {1'b0, n_eff};
	assign out_free = !ov_q || !out_stall;
	assign age_inc  = (age_q == AGE_LIMIT) ? age_q : age_q + AGE_W'(1);
	assign age_clip = (age_q > {1'b0, n_eff}) ? n_eff : age_q[IDX_W-1:0];
	assign num      = NUM_W'(Q8_FULL_SCALE) * NUM_W'(n_eff - age_clip);

	// cell 0 holds the newest sample; a token started at cell n walks down to
	// cell 0 carrying the newest maximum and its age
	for (genvar j = 0; j < WINDOW_MAX; j++) begin : g_cell
		sample_t smp_in;
		tok_t    tok_in;

		if (j == 0) begin : g_head
			assign smp_in = key;
		end else begin : g_body
			assign smp_in = cell_smp[j-1];
		end

		if (j == WINDOW_MAX - 1) begin : g_tail
			assign tok_in = '0;
		end else begin : g_link
			assign tok_in = cell_tok[j+1];
		end

		aru_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.shift_en   (accept),
			.sample_in  (smp_in),
			.sample_out (cell_smp[j]),
			.start      (scan_start && (n_eff == IDX_W'(j))),
			.tok_in     (tok_in),
			.tok_out    (cell_tok[j])
		);
	end

	aru_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num),
		.den    (n_eff),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (warm) begin
						state_d = ST_DONE;
					end else if (rescan) begin
						state_d = ST_SCAN_START;
					end else begin
						state_d = ST_MUL;
					end
				end
			end
			ST_SCAN_START: state_d = ST_SCAN;
			ST_SCAN: begin
				if (cell_tok[0].v) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: state_d = ST_DIV;
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall   = 1'b1;
		scan_start = 1'b0;
		div_start  = 1'b0;
		out_load   = 1'b0;
		case (state_q)
			ST_IDLE:       in_stall = 1'b0;
			ST_SCAN_START: scan_start = 1'b1;
			ST_MUL:        div_start = 1'b1;
			ST_DONE:       out_load = out_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			window_q <= WINDOW_N_RESET;
			wcnt_q   <= '0;
			age_q    <= '0;
			ov_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				window_q <= window_n;
				wcnt_q   <= '0;
				age_q    <= '0;
			end else if (accept) begin
				if (warm) begin
					wcnt_q <= wcnt_q + IDX_W'(1);
					// first sample after a restart takes the maximum outright
					if (wcnt_q == '0 || key >= cur_q) begin
						age_q <= AGE_W'(1);
					end else begin
						age_q <= age_inc;
					end
				end else if (!rescan && key >= cur_q) begin
					age_q <= '0;
				end
			end else if (state_q == ST_SCAN && cell_tok[0].v) begin
				age_q <= AGE_W'(cell_tok[0].gap);
			end else if (state_q == ST_MUL) begin
				age_q <= age_inc;
			end

			if (out_load) begin
				ov_q <= 1'b1;
			end else if (!out_stall) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (warm) begin
				if (wcnt_q == '0 || key >= cur_q) begin
					cur_q <= key;
				end
				res_valid_q <= 1'b0;
				res_pct_q   <= '0;
			end else if (!rescan && key >= cur_q) begin
				cur_q <= key;
			end
		end else if (state_q == ST_SCAN && cell_tok[0].v) begin
			cur_q <= cell_tok[0].best;
		end else if (state_q == ST_DIV && div_done) begin
			res_valid_q <= 1'b1;
			res_pct_q   <= div_quot;
		end

		if (out_load) begin
			orv_q  <= res_valid_q;
			opct_q <= res_pct_q;
		end
	end

	assign out_valid        = ov_q;
	assign result_valid     = orv_q;
	assign aroon_percent_q8 = opct_q;

endmodule

[sv/aru_chk.sv]
module aru_chk (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_stall,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic                               result_valid,
	input logic [aru_pkg::PCT_W-1:0]          aroon_percent_q8
);
	import aru_pkg::*;

	// a stalled request keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_valid)
			&& $stable(aroon_percent_q8))
		else $error("output request changed while stalled");

	a_warmup_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !result_valid |-> aroon_percent_q8 == '0)
		else $error("warm-up request carries a nonzero value");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> aroon_percent_q8 <= Q8_FULL_SCALE)
		else $error("percent above full scale");

	// one sample at a time: the block is busy right after taking one
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken on consecutive cycles");

endmodule

bind aroon_up_rolling_max_age_top aru_chk u_aru_chk (.*);

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
	import aru_pkg::*;

	typedef struct packed {
		logic             valid;
		logic [PCT_W-1:0] pct;
	} aroon_res_t;

	typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t        kind;
		logic [31:0]      value;
		bit               typed;
		logic             exp_valid;
		logic [PCT_W-1:0] exp_pct;
	} row_t;

	localparam int ROWS = 24;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 112;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 100;

	localparam logic [31:0] S_MIN = 32'h8000_0000;
	localparam logic [31:0] S_MAX = 32'h7FFF_FFFF;

	logic                       clk;
	logic                       arst_n = 1'b0;
	logic                       cfg_wr_en = 1'b0;
	logic [IDX_W-1:0]           window_n = '0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic signed [SAMPLE_W-1:0] sample = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic                       result_valid;
	logic [PCT_W-1:0]           aroon_percent_q8;

	aroon_up_rolling_max_age_top dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.window_n         (window_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.sample           (sample),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.result_valid     (result_valid),
		.aroon_percent_q8 (aroon_percent_q8)
	);

	// predictor state, samples kept as offset-binary keys
	sample_t          hist_key [WINDOW_MAX];
	logic [IDX_W-1:0] wr_ptr = '0;
	sample_t          max_key = '0;
	logic [AGE_W-1:0] max_age = '0;
	logic [AGE_W-1:0] warm_cnt = '0;
	logic [IDX_W-1:0] win_reg = WINDOW_N_RESET;

	aroon_res_t aroon_expected_q [$];
	aroon_res_t want;
	int         mismatch_count = 0;
	int         send_idle_pct = 0;
	int         recv_stall_pct = 0;
	int         hold_asked = 0;
	int         hold_served = 0;
	int         hold_left = 0;
	row_t       script [ROWS];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic aroon_res_t aroon_up_next(input logic [31:0] s);
		int unsigned n;
		int unsigned here;
		int unsigned at;
		int unsigned age;
		sample_t     key;
		aroon_res_t  r;
		n = (win_reg == 0) ? 1 : win_reg;
		key = s ^ SIGN_BIT;
		here = wr_ptr;
		hist_key[here] = key;
		wr_ptr = wr_ptr + 1'b1;
		r = '0;
		if (warm_cnt < n) begin
			if (warm_cnt == 0 || key >= max_key) begin
				max_key = key;
				max_age = '0;
			end
			warm_cnt = warm_cnt + 1'b1;
			if (max_age < AGE_LIMIT)
				max_age = max_age + 1'b1;
			return r;
		end
		if (max_age > n) begin
			// maximum aged out: search the window, strict compare keeps the newest
			max_key = key;
			max_age = '0;
			for (int unsigned j = 1; j <= n; j++) begin
				at = (here + WINDOW_MAX - j) % WINDOW_MAX;
				if (hist_key[at] > max_key) begin
					max_key = hist_key[at];
					max_age = AGE_W'(j);
				end
			end
		end else if (key >= max_key) begin
			max_key = key;
			max_age = '0;
		end
		age = (max_age > n) ? n : max_age;
		r.valid = 1'b1;
		r.pct = PCT_W'((Q8_FULL_SCALE * (n - age)) / n);
		if (max_age < AGE_LIMIT)
			max_age = max_age + 1'b1;
		return r;
	endfunction

	function automatic logic [31:0] next_sample(input logic [31:0] prev);
		logic [31:0] v;
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 3))
					0: v = S_MIN;
					1: v = S_MAX;
					2: v = '0;
					default: v = '1;
				endcase
			end
			1, 2, 3: v = $urandom;
			4, 5: v = 32'($urandom_range(0, 6)) - 32'd3;
			6: v = prev + 32'($urandom_range(0, 2));
			// falling runs let the maximum age out of the window
			default: v = prev - 32'($urandom_range(0, 2));
		endcase
		return v;
	endfunction

	task automatic offer_sample(input logic [31:0] s, input bit typed, input aroon_res_t fixed);
		aroon_res_t pred;
		sample <= s;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pred = aroon_up_next(s);
		aroon_expected_q.push_back(typed ? fixed : pred);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < send_idle_pct)
				@(posedge clk);
		end
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (aroon_expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_window(input logic [IDX_W-1:0] v);
		drain();
		cfg_wr_en <= 1'b1;
		window_n <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		win_reg = v;
		wr_ptr = '0;
		max_age = '0;
		warm_cnt = '0;
	endtask

	// receiver: stalls, long hold-off on request, and result checking
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (aroon_expected_q.size() == 0) begin
				$display("%0t: unexpected result valid %0b pct %0d", $time,
					result_valid, aroon_percent_q8);
				mismatch_count++;
			end else begin
				want = aroon_expected_q.pop_front();
				if (result_valid !== want.valid) begin
					$display("%0t: result_valid expected %0b actual %0b", $time,
						want.valid, result_valid);
					mismatch_count++;
				end
				if (aroon_percent_q8 !== want.pct) begin
					$display("%0t: aroon_percent_q8 expected %0d actual %0d", $time,
						want.pct, aroon_percent_q8);
					mismatch_count++;
				end
			end
		end
		if (hold_served != hold_asked) begin
			hold_served = hold_asked;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	initial begin
		logic [IDX_W-1:0] phase_win [PHASES];
		logic [31:0]      prev;
		aroon_res_t       fixed;

		phase_win = '{6'd20, 6'd63, 6'd2, 6'd0, 6'd13, 6'd63, 6'd1, 6'd37};
		script = '{
			'{ROW_SAMPLE, S_MAX,        1, 1'b0, 15'd0},
			'{ROW_SAMPLE, S_MIN,        1, 1'b0, 15'd0},
			'{ROW_WRITE,  32'd0,        0, 1'b0, 15'd0},
			'{ROW_SAMPLE, S_MIN,        1, 1'b0, 15'd0},
			'{ROW_SAMPLE, S_MAX,        1, 1'b1, 15'd25600},
			'{ROW_SAMPLE, S_MIN,        1, 1'b1, 15'd0},
			'{ROW_SAMPLE, S_MIN,        0, 1'b0, 15'd0},
			'{ROW_SAMPLE, S_MIN,        0, 1'b0, 15'd0},
			'{ROW_WRITE,  32'd3,        0, 1'b0, 15'd0},
			'{ROW_SAMPLE, 32'd5,        1, 1'b0, 15'd0},
			'{ROW_SAMPLE, 32'd7,        1, 1'b0, 15'd0},
			'{ROW_SAMPLE, 32'd7,        1, 1'b0, 15'd0},
			'{ROW_SAMPLE, 32'hFFFF_FFFF, 0, 1'b0, 15'd0},
			'{ROW_SAMPLE, 32'hFFFF_FFFE, 0, 1'b0, 15'd0},
			'{ROW_SAMPLE, 32'hFFFF_FFFD, 0, 1'b0, 15'd0},
			'{ROW_SAMPLE, 32'hFFFF_FFFC, 0, 1'b0, 15'd0},
			'{ROW_SAMPLE, 32'd0,        0, 1'b0, 15'd0},
			'{ROW_WRITE,  32'd63,       0, 1'b0, 15'd0},
			'{ROW_SAMPLE, 32'd0,        1, 1'b0, 15'd0},
			'{ROW_WRITE,  32'd1,        0, 1'b0, 15'd0},
			'{ROW_SAMPLE, 32'd0,        1, 1'b0, 15'd0},
			'{ROW_SAMPLE, 32'd0,        1, 1'b1, 15'd25600},
			'{ROW_SAMPLE, 32'h5555_5555, 0, 1'b0, 15'd0},
			'{ROW_SAMPLE, 32'hAAAA_AAAA, 0, 1'b0, 15'd0}
		};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			if (script[i].kind == ROW_WRITE) begin
				set_window(IDX_W'(script[i].value));
			end else begin
				fixed.valid = script[i].exp_valid;
				fixed.pct = script[i].exp_pct;
				offer_sample(script[i].value, script[i].typed, fixed);
			end
		end

		prev = $urandom;
		fixed = '0;
		for (int p = 0; p < PHASES; p++) begin
			set_window(phase_win[p]);
			case (p % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 74;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 74;
				end
				default: begin
					send_idle_pct = 31;
					recv_stall_pct = 31;
				end
			endcase
			// long receiver hold-off while requests keep coming
			if (p == 0)
				hold_asked++;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				prev = next_sample(prev);
				offer_sample(prev, 0, fixed);
			end
		end

		drain();
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
